// ===== rtl/log_line_ring_buffer_assert.svh =====
// assertion macros for the line ring buffer checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef LOG_LINE_RING_BUFFER_ASSERT_SVH
`define LOG_LINE_RING_BUFFER_ASSERT_SVH

// checked only while out of reset
`define LRB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define LRB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/lrb_pkg.sv =====
// shared constants for the log line ring buffer
// no dependencies
package lrb_pkg;

    // beat field widths
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 5;
    localparam int OFFSET_W = 7;
    localparam int HELD_W   = 6;
    localparam int REV_W    = 32;

    // action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // special bytes
    localparam logic [BYTE_W-1:0] NL_BYTE   = 8'd10;
    localparam logic [BYTE_W-1:0] CR_BYTE   = 8'd13;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'd0;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

endpackage

// ===== rtl/lrb_if.sv =====
// valid/ready channel interfaces for the log line ring buffer
// depends on lrb_pkg
interface lrb_in_if;
    import lrb_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [BYTE_W-1:0]   byte_in;
    logic                chunk_end;
    logic [INDEX_W-1:0]  line_index;
    logic [OFFSET_W-1:0] char_offset;

    modport source (output valid, action, byte_in, chunk_end, line_index, char_offset,
                    input ready);
    modport sink   (input valid, action, byte_in, chunk_end, line_index, char_offset,
                    output ready);
endinterface

interface lrb_out_if;
    import lrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_char;
    logic              read_valid;
    logic [HELD_W-1:0] lines_held;
    logic [REV_W-1:0]  revision_count;

    modport source (output valid, read_char, read_valid, lines_held, revision_count,
                    input ready);
    modport sink   (input valid, read_char, read_valid, lines_held, revision_count,
                    output ready);
endinterface

// ===== rtl/lrb_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module lrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/lrb_front.sv =====
// front end: accepts beats, tracks head, count, pending length and revision,
// and turns each beat into one memory command; depends on lrb_pkg, lrb_if
module lrb_front #(
    parameter int  LINES    = 32,
    parameter int  LINE_LEN = 128,
    parameter type t_cmd    = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lrb_in_if.sink i_in,
    output t_cmd  o_cmd,
    output logic  o_cmd_valid,
    input  logic  i_cmd_ready
);
    import lrb_pkg::*;

    localparam int SLOTS  = LINES + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LEN_W  = $clog2(LINE_LEN);
    localparam int CMP_W  = (INDEX_W > SLOT_W) ? INDEX_W : SLOT_W;
    localparam int SUM_W  = CMP_W + 1;

    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_held, n_held;
    logic [LEN_W-1:0]  r_pend, n_pend;
    logic [REV_W-1:0]  r_rev,  n_rev;

    logic              accept;
    logic              is_push, is_nl, is_cr, pend_full;
    logic              commit, append;
    logic [SLOT_W-1:0] head_inc;
    logic [SUM_W-1:0]  sum, wrapped, slot;
    logic              hit;

    assign i_in.ready  = i_cmd_ready;
    assign o_cmd_valid = i_in.valid;
    assign accept      = i_in.valid && i_cmd_ready;

    // classify the beat
    always_comb begin
        is_push   = (i_in.action == ACT_PUSH);
        is_nl     = (i_in.byte_in == NL_BYTE);
        is_cr     = (i_in.byte_in == CR_BYTE);
        pend_full = (r_pend == LEN_W'(LINE_LEN - 1));
        commit    = is_push && (is_nl || (!is_cr && pend_full));
        append    = is_push && !is_nl && !is_cr;
    end

    // next ring state; the head slot is always the spare that takes the pending line
    always_comb begin
        head_inc = (r_head == SLOT_W'(SLOTS - 1)) ? '0 : r_head + 1'b1;
        n_head   = commit ? head_inc : r_head;
        n_held   = (commit && (r_held != SLOT_W'(LINES))) ? r_held + 1'b1 : r_held;
        n_rev    = commit ? r_rev + 1'b1 : r_rev;
        if (commit) begin
            n_pend = append ? LEN_W'(1) : '0;
        end else if (append) begin
            n_pend = r_pend + 1'b1;
        end else begin
            n_pend = r_pend;
        end
    end

    // physical slot of a read: head - held + index, modulo the slot count
    always_comb begin
        hit     = !is_push && (CMP_W'(i_in.line_index) < CMP_W'(r_held));
        sum     = SUM_W'(r_head) + SUM_W'(i_in.line_index);
        wrapped = (sum >= SUM_W'(SLOTS)) ? sum - SUM_W'(SLOTS) : sum;
        slot    = (wrapped >= SUM_W'(r_held)) ? wrapped - SUM_W'(r_held)
                                              : wrapped + SUM_W'(SLOTS) - SUM_W'(r_held);
    end

    // build the command
    always_comb begin
        o_cmd           = '0;
        o_cmd.is_read   = !is_push;
        o_cmd.rd_hit    = hit;
        o_cmd.rd_slot   = slot[SLOT_W-1:0];
        o_cmd.rd_offset = i_in.char_offset;
        o_cmd.data_we   = append;
        o_cmd.wr_slot   = n_head;
        o_cmd.wr_offset = commit ? '0 : r_pend;
        o_cmd.wr_byte   = i_in.byte_in;
        o_cmd.len_we    = commit;
        o_cmd.len_slot  = r_head;
        o_cmd.len_value = r_pend;
        o_cmd.held      = n_held;
        o_cmd.revision  = n_rev;
    end

    // ring bookkeeping registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_held <= '0;
            r_pend <= '0;
            r_rev  <= '0;
        end else if (accept) begin
            r_head <= n_head;
            r_held <= n_held;
            r_pend <= n_pend;
            r_rev  <= n_rev;
        end
    end
endmodule

// ===== rtl/lrb_queue.sv =====
// short command queue that decouples the front end from the back end
// depends on lrb_pkg
module lrb_queue #(
    parameter type t_cmd = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_data,
    input  logic i_valid,
    output logic o_ready,
    output t_cmd o_data,
    output logic o_valid,
    input  logic i_ready
);
    import lrb_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push, pop;

    assign o_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/lrb_back.sv =====
// back end: executes commands on the line store and length memories and
// drives the result register; depends on lrb_pkg, lrb_if, lrb_ram
module lrb_back #(
    parameter int  LINES    = 32,
    parameter int  LINE_LEN = 128,
    parameter type t_cmd    = logic
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    input  logic     i_cmd_valid,
    output logic     o_cmd_ready,
    lrb_out_if.source o_out
);
    import lrb_pkg::*;

    localparam int SLOTS      = LINES + 1;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int LEN_W      = $clog2(LINE_LEN);
    localparam int DATA_DEPTH = SLOTS << LEN_W;
    localparam int OCMP_W     = (OFFSET_W > LEN_W) ? OFFSET_W : LEN_W;

    logic              r_s1_valid;
    t_cmd              r_s1_cmd;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_read_char;
    logic              r_read_valid;
    logic [HELD_W-1:0] r_lines_held;
    logic [REV_W-1:0]  r_rev;

    logic              out_free, s1_move, pop;
    logic [BYTE_W-1:0] data_rd;
    logic [LEN_W-1:0]  len_rd;
    logic              in_line;
    logic [BYTE_W-1:0] n_read_char;

    // pipeline flow
    assign out_free    = !r_out_valid || o_out.ready;
    assign s1_move     = r_s1_valid && out_free;
    assign o_cmd_ready = !r_s1_valid || s1_move;
    assign pop         = i_cmd_valid && o_cmd_ready;

    // line bytes, one row of 2^LEN_W per slot
    lrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (pop && i_cmd.data_we),
        .i_waddr ({i_cmd.wr_slot, i_cmd.wr_offset}),
        .i_wdata (i_cmd.wr_byte),
        .i_re    (pop && i_cmd.is_read),
        .i_raddr ({i_cmd.rd_slot, LEN_W'(i_cmd.rd_offset)}),
        .o_rdata (data_rd)
    );

    // committed length per slot
    lrb_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (pop && i_cmd.len_we),
        .i_waddr (i_cmd.len_slot),
        .i_wdata (i_cmd.len_value),
        .i_re    (pop && i_cmd.is_read),
        .i_raddr (i_cmd.rd_slot),
        .o_rdata (len_rd)
    );

    // memory access stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_cmd_ready) begin
            r_s1_valid <= i_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_cmd <= i_cmd;
        end
    end

    // pick the byte, zero past the line end or for a miss
    always_comb begin
        in_line     = OCMP_W'(r_s1_cmd.rd_offset) < OCMP_W'(len_rd);
        n_read_char = (r_s1_cmd.rd_hit && in_line) ? data_rd : ZERO_BYTE;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_read_char  <= n_read_char;
            r_read_valid <= r_s1_cmd.rd_hit;
            r_lines_held <= HELD_W'(r_s1_cmd.held);
            r_rev        <= r_s1_cmd.revision;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.read_char      = r_read_char;
    assign o_out.read_valid     = r_read_valid;
    assign o_out.lines_held     = r_lines_held;
    assign o_out.revision_count = r_rev;
endmodule

// ===== rtl/log_line_ring_buffer.sv =====
// top level of the log line ring buffer
// depends on lrb_pkg, lrb_if, lrb_front, lrb_queue, lrb_back
//
// Builds lines from a pushed byte stream and keeps the most recent LINES of them;
// newline commits the pending line, carriage return is dropped, and a line reaching
// LINE_LEN-1 bytes is committed before the next byte. Read beats return one byte of
// a retained line (index 0 = oldest) together with the line count and commit
// revision. Throughput is one beat per clock while the output is not stalled: each
// beat is at most one write or one read of the line store, whose single write port
// and single registered read port set that figure. A beat passes through the
// command queue, then the memory read, then the result register, and a two-entry
// queue lets input and output stall independently. The store holds LINES+1 rows of
// 2^ceil(log2(LINE_LEN)) bytes, one row being the line under construction, plus a
// LINES+1 entry length memory; neither needs clearing after reset.
module log_line_ring_buffer #(
    parameter int LINES    = 32,
    parameter int LINE_LEN = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lrb_in_if.sink    i_in,
    lrb_out_if.source o_out
);
    import lrb_pkg::*;

    localparam int SLOTS  = LINES + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LEN_W  = $clog2(LINE_LEN);

    typedef struct packed {
        logic                is_read;
        logic                rd_hit;
        logic [SLOT_W-1:0]   rd_slot;
        logic [OFFSET_W-1:0] rd_offset;
        logic                data_we;
        logic [SLOT_W-1:0]   wr_slot;
        logic [LEN_W-1:0]    wr_offset;
        logic [BYTE_W-1:0]   wr_byte;
        logic                len_we;
        logic [SLOT_W-1:0]   len_slot;
        logic [LEN_W-1:0]    len_value;
        logic [SLOT_W-1:0]   held;
        logic [REV_W-1:0]    revision;
    } t_cmd;

    t_cmd front_cmd, back_cmd;
    logic front_valid, front_ready;
    logic back_valid, back_ready;

    // classify beats and keep the ring pointers
    lrb_front #(
        .LINES    (LINES),
        .LINE_LEN (LINE_LEN),
        .t_cmd    (t_cmd)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready)
    );

    // decoupling queue
    lrb_queue #(
        .t_cmd (t_cmd)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (front_cmd),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .o_data  (back_cmd),
        .o_valid (back_valid),
        .i_ready (back_ready)
    );

    // memories and result register
    lrb_back #(
        .LINES    (LINES),
        .LINE_LEN (LINE_LEN),
        .t_cmd    (t_cmd)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .o_out       (o_out)
    );
endmodule

// ===== rtl/lrb_checker.sv =====
// port level checks for the log line ring buffer, bound to the top level
// depends on lrb_pkg and log_line_ring_buffer_assert.svh
`include "log_line_ring_buffer_assert.svh"

module lrb_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [lrb_pkg::BYTE_W-1:0] i_read_char,
    input logic                      i_read_valid,
    input logic [lrb_pkg::HELD_W-1:0] i_lines_held,
    input logic [lrb_pkg::REV_W-1:0]  i_revision_count
);
    import lrb_pkg::*;

    logic              r_seen;
    logic [HELD_W-1:0] r_last_held;
    logic [REV_W-1:0]  r_last_rev;
    logic              out_beat;

    assign out_beat = i_out_valid && i_out_ready;

    // remember the previous result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_beat) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_beat) begin
            r_last_held <= i_lines_held;
            r_last_rev  <= i_revision_count;
        end
    end

    `LRB_ASSERT_RST(a_reset_clears_out, (!i_rst_n) |=> (!i_out_valid), "result valid after reset")
    `LRB_ASSERT(a_out_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_read_char) && $stable(i_read_valid) && $stable(i_lines_held) && $stable(i_revision_count)), "stalled result changed")
    `LRB_ASSERT(a_rev_step, (out_beat && r_seen) |-> ((i_revision_count == r_last_rev) || (i_revision_count == r_last_rev + 32'd1)), "revision skipped between results")
    `LRB_ASSERT(a_held_step, (out_beat && r_seen) |-> (((i_revision_count != r_last_rev) || (i_lines_held == r_last_held)) && ((i_lines_held == r_last_held) || (i_lines_held == r_last_held + 6'd1))), "line count moved without a commit")
endmodule

bind log_line_ring_buffer lrb_checker u_lrb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_read_char      (o_out.read_char),
    .i_read_valid     (o_out.read_valid),
    .i_lines_held     (o_out.lines_held),
    .i_revision_count (o_out.revision_count)
);

// ===== tb/testbench.sv =====
// testbench for log_line_ring_buffer: byte pushes and line reads over valid/ready
// depends on lrb_pkg, lrb_if and the log_line_ring_buffer rtl
`timescale 1ns / 1ps

module testbench;
    import lrb_pkg::*;

    localparam int NUM_LINES      = 32;
    localparam int LINE_BYTES     = 128;
    localparam int CLK_PERIOD_NS  = 12;
    localparam int TIMEOUT_CYCLES = 200_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] read_char;
        logic              read_valid;
        logic [HELD_W-1:0] lines_held;
        logic [REV_W-1:0]  revision_count;
    } t_line_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lrb_in_if  in_if ();
    lrb_out_if out_if ();

    log_line_ring_buffer #(
        .LINES    (NUM_LINES),
        .LINE_LEN (LINE_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #(CLK_PERIOD_NS / 2.0) i_clk = ~i_clk;

    // predicted state of the line ring
    logic [BYTE_W-1:0] ring_bytes [NUM_LINES][LINE_BYTES];
    int                ring_len   [NUM_LINES];
    logic [BYTE_W-1:0] pend_bytes [LINE_BYTES];
    int                pend_len   = 0;
    int                head       = 0;
    int                held       = 0;
    logic [REV_W-1:0]  revision   = '0;

    t_line_result expected_results [$];
    int           mismatches = 0;

    // idle and stall rates, percent of cycles
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;

    // store the pending line in the head slot
    task automatic commit_pending();
        for (int k = 0; k < pend_len; k++) ring_bytes[head][k] = pend_bytes[k];
        ring_len[head] = pend_len;
        head = (head + 1) % NUM_LINES;
        if (held < NUM_LINES) held++;
        revision = revision + 1'b1;
        pend_len = 0;
    endtask

    // apply one beat to the predicted state and queue its result
    task automatic predict_beat(input logic act, input logic [BYTE_W-1:0] b,
                                input logic [INDEX_W-1:0] idx,
                                input logic [OFFSET_W-1:0] off);
        t_line_result r;
        int           slot;
        r = '0;
        if (act == ACT_PUSH) begin
            if (b == NL_BYTE) begin
                commit_pending();
            end else if (b != CR_BYTE) begin
                if (pend_len >= LINE_BYTES - 1) commit_pending();
                pend_bytes[pend_len] = b;
                pend_len++;
            end
        end else if (int'(idx) < held) begin
            slot = (head + NUM_LINES - held + int'(idx)) % NUM_LINES;
            r.read_valid = 1'b1;
            if (int'(off) < ring_len[slot]) r.read_char = ring_bytes[slot][off];
        end
        r.lines_held     = held[HELD_W-1:0];
        r.revision_count = revision;
        expected_results.push_back(r);
    endtask

    // drive one beat, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_beat(input logic act, input logic [BYTE_W-1:0] b, input logic ce,
                             input logic [INDEX_W-1:0] idx,
                             input logic [OFFSET_W-1:0] off);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_beat(act, b, idx, off);
        in_if.valid       <= 1'b1;
        in_if.action      <= act;
        in_if.byte_in     <= b;
        in_if.chunk_end   <= ce;
        in_if.line_index  <= idx;
        in_if.char_offset <= off;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // push beat with random don't-care fields
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        send_beat(ACT_PUSH, b, 1'($urandom_range(0, 1)), INDEX_W'($urandom),
                  OFFSET_W'($urandom));
    endtask

    // read beat with random ignored byte
    task automatic read_char_at(input int idx, input int off);
        send_beat(ACT_READ, BYTE_W'($urandom), 1'($urandom_range(0, 1)),
                  INDEX_W'(idx), OFFSET_W'(off));
    endtask

    // any byte that is neither newline nor carriage return
    function automatic logic [BYTE_W-1:0] text_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom); while (b == NL_BYTE || b == CR_BYTE);
        return b;
    endfunction

    // read mostly retained lines within or just past their length, sometimes anything
    task automatic read_retained();
        int idx;
        int off;
        int slot;
        if (held > 0 && $urandom_range(0, 99) < 80) begin
            idx  = $urandom_range(0, held - 1);
            slot = (head + NUM_LINES - held + idx) % NUM_LINES;
            if ($urandom_range(0, 99) < 70) off = $urandom_range(0, ring_len[slot]);
            else off = $urandom_range(0, LINE_BYTES - 1);
        end else begin
            idx = $urandom_range(0, NUM_LINES - 1);
            off = $urandom_range(0, LINE_BYTES - 1);
        end
        read_char_at(idx, off);
    endtask

    // stop sending and wait for every predicted result
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_field(input string field, input logic [REV_W-1:0] want,
                                input logic [REV_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_line_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result beat with no prediction pending");
            end else begin
                want = expected_results.pop_front();
                report_field("read_char", REV_W'(want.read_char),
                             REV_W'(out_if.read_char));
                report_field("read_valid", REV_W'(want.read_valid),
                             REV_W'(out_if.read_valid));
                report_field("lines_held", REV_W'(want.lines_held),
                             REV_W'(out_if.lines_held));
                report_field("revision_count", want.revision_count, out_if.revision_count);
            end
        end
    end

    // receiver back-pressure
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // empty ring, special bytes, empty lines, reads out of range and past the end
    task automatic test_directed();
        read_char_at(0, 0);
        read_char_at(NUM_LINES - 1, LINE_BYTES - 1);
        send_beat(ACT_PUSH, 8'h48, 1'b0, '0, '0);
        send_beat(ACT_PUSH, ZERO_BYTE, 1'b0, '1, '1);
        push_byte(CR_BYTE);
        send_beat(ACT_PUSH, 8'hFF, 1'b1, '0, '0);
        push_byte(NL_BYTE);
        push_byte(NL_BYTE);
        read_char_at(0, 0);
        read_char_at(0, 1);
        read_char_at(0, 2);
        read_char_at(0, 3);
        read_char_at(0, LINE_BYTES - 1);
        read_char_at(1, 0);
        read_char_at(2, 0);
        push_byte(8'h78);
        push_byte(CR_BYTE);
        push_byte(NL_BYTE);
        read_char_at(2, 0);
        read_char_at(2, 1);
        read_char_at(NUM_LINES - 1, 0);
    endtask

    // a line longer than a slot wraps onto the next one
    task automatic test_long_lines();
        for (int k = 0; k < LINE_BYTES + 2; k++) push_byte(text_byte());
        push_byte(NL_BYTE);
        read_char_at(held - 2, 0);
        read_char_at(held - 2, LINE_BYTES - 2);
        read_char_at(held - 2, LINE_BYTES - 1);
        read_char_at(held - 1, 2);
        read_char_at(held - 1, 3);
    endtask

    // random log lines with reads in between, plus some raw noise
    task automatic test_log_traffic(input int n_beats);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < n_beats) begin
            if ($urandom_range(0, 99) < 75) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) len = $urandom_range(0, 12);
                else if (pick < 97) len = $urandom_range(13, 60);
                else len = $urandom_range(LINE_BYTES - 8, LINE_BYTES + 8);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 19) == 0) push_byte(CR_BYTE);
                    else begin
                        push_byte(text_byte());
                        sent++;
                    end
                end
                push_byte(NL_BYTE);
                sent++;
                repeat ($urandom_range(0, 4)) begin
                    read_retained();
                    sent++;
                end
            end else begin
                if ($urandom_range(0, 1) == 0) push_byte(BYTE_W'($urandom));
                else read_char_at($urandom_range(0, NUM_LINES - 1),
                                  $urandom_range(0, LINE_BYTES - 1));
                sent++;
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.action      <= ACT_PUSH;
        in_if.byte_in     <= '0;
        in_if.chunk_end   <= 1'b0;
        in_if.line_index  <= '0;
        in_if.char_offset <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        test_long_lines();
        wait_drained();

        src_idle_pct = 0;  sink_stall_pct = 0;
        test_log_traffic(100);
        wait_drained();
        src_idle_pct = 57; sink_stall_pct = 0;
        test_log_traffic(100);
        wait_drained();
        src_idle_pct = 0;  sink_stall_pct = 57;
        test_log_traffic(100);
        wait_drained();
        src_idle_pct = 9;  sink_stall_pct = 9;
        test_log_traffic(100);
        wait_drained();

        if (expected_results.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
